@@ rtl/cdda_pkg.sv @@
// Shared types, constants and calendar helper functions for the date arithmetic block.
`timescale 1ns / 1ps

package cdda_pkg;

  // Mode codes carried by each input beat.
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // Calendar limits and day counts (origin 0000-03-01).
  localparam logic [13:0] YEAR_MIN        = 14'd1;
  localparam logic [13:0] YEAR_MAX        = 14'd9999;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
  localparam logic [8:0]  JAN1_OFFSET     = 9'd306;
  localparam logic [21:0] DAY_FIRST       = 22'd306;
  localparam logic [21:0] DAY_LAST        = 22'd3652364;
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam logic [6:0]  CENTURY         = 7'd100;
  localparam logic [3:0]  YEAR_MSB        = 4'd13;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_START_DAYS,
    OP_OTHER_DAYS,
    OP_RANGE,
    OP_YEAR_EVAL,
    OP_YEAR_DECIDE,
    OP_LEAP,
    OP_MONTH_STEP,
    OP_EMIT_ERROR,
    OP_EMIT_DIFF,
    OP_EMIT_DATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t       op;
    status_code_t err_code;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic other_ok;
    logic mode_ok;
    logic is_diff;
    logic in_range;
    logic search_last;
    logic month_found;
  } stat_t;

  // Quotient by 100 through a reciprocal multiply; exact for any 14-bit value.
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'(RECIP_100);
    return prod[26:19];
  endfunction

  // Gregorian leap rule.
  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [14:0] back;
    logic        cent;
    q    = div100(y);
    back = 15'(q) * 15'(CENTURY);
    cent = (back == 15'(y));
    return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
  endfunction

  // Days before the March-based year x, counted from the origin: x*365 + x/4 - x/100 + x/400.
  function automatic logic [21:0] year_days(input logic [13:0] x);
    logic [7:0]  q;
    logic [22:0] sum;
    q   = div100(x);
    sum = 23'(x) * 23'(DAYS_PER_YEAR) + 23'(x[13:2]) - 23'(q) + 23'(q[7:2]);
    return sum[21:0];
  endfunction

  // Length of a calendar month; zero for a month code that means nothing.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of month m in a March-based year.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d);
    logic yok;
    logic mok;
    yok = (y >= YEAR_MIN) && (y <= YEAR_MAX);
    mok = (m >= 4'd1) && (m <= MONTHS_PER_YEAR);
    return yok && mok && (d >= 5'd1) && (d <= month_len(is_leap(y), m));
  endfunction

endpackage

@@ rtl/cdda_ctrl.sv @@
// Controller state machine that sequences the date datapath for one beat at a time.
`timescale 1ns / 1ps

module cdda_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  cdda_pkg::stat_t stat,
  output cdda_pkg::cmd_t  cmd
);
  import cdda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_OTHER,
    S_DIFF,
    S_RANGE,
    S_RANGE_CHK,
    S_YEVAL,
    S_YDEC,
    S_LEAP,
    S_MONTH
  } state_t;

  state_t state;
  state_t state_next;
  logic   busy_next;
  logic   done_next;

  // Next state, registered outputs and the command for the datapath.
  always_comb begin
    state_next   = state;
    busy_next    = busy;
    done_next    = 1'b0;
    cmd.op       = OP_NONE;
    cmd.err_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
          busy_next  = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.mode_ok || !stat.start_ok || (stat.is_diff && !stat.other_ok)) begin
          cmd.op       = OP_EMIT_ERROR;
          cmd.err_code = ST_INVALID;
          done_next    = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
        end else begin
          cmd.op     = OP_START_DAYS;
          state_next = stat.is_diff ? S_OTHER : S_RANGE;
        end
      end
      S_OTHER: begin
        cmd.op     = OP_OTHER_DAYS;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_EMIT_DIFF;
        done_next  = 1'b1;
        busy_next  = 1'b0;
        state_next = S_IDLE;
      end
      S_RANGE: begin
        cmd.op     = OP_RANGE;
        state_next = S_RANGE_CHK;
      end
      S_RANGE_CHK: begin
        if (!stat.in_range) begin
          cmd.op       = OP_EMIT_ERROR;
          cmd.err_code = ST_RANGE;
          done_next    = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
        end else begin
          state_next = S_YEVAL;
        end
      end
      S_YEVAL: begin
        cmd.op     = OP_YEAR_EVAL;
        state_next = S_YDEC;
      end
      S_YDEC: begin
        cmd.op     = OP_YEAR_DECIDE;
        state_next = stat.search_last ? S_LEAP : S_YEVAL;
      end
      S_LEAP: begin
        cmd.op     = OP_LEAP;
        state_next = S_MONTH;
      end
      S_MONTH: begin
        if (stat.month_found) begin
          cmd.op     = OP_EMIT_DATE;
          done_next  = 1'b1;
          busy_next  = 1'b0;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_MONTH_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
        busy_next  = 1'b0;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      done  <= done_next;
    end
  end

endmodule

@@ rtl/cdda_dp.sv @@
// Datapath: input registers, shared day-count unit, year search and month walk.
`timescale 1ns / 1ps

module cdda_dp (
  input  logic            clk,
  input  cdda_pkg::cmd_t  cmd,
  output cdda_pkg::stat_t stat,
  input  logic [1:0]      mode,
  input  logic [13:0]     start_year,
  input  logic [3:0]      start_month,
  input  logic [4:0]      start_day,
  input  logic [21:0]     offset_days,
  input  logic [13:0]     other_year,
  input  logic [3:0]      other_month,
  input  logic [4:0]      other_day,
  output logic [13:0]     result_year,
  output logic [3:0]      result_month,
  output logic [4:0]      result_day,
  output logic [22:0]     day_difference,
  output logic [1:0]      status
);
  import cdda_pkg::*;

  // Captured input beat.
  logic [1:0]  in_mode;
  logic [13:0] in_sy;
  logic [3:0]  in_sm;
  logic [4:0]  in_sd;
  logic [21:0] in_off;
  logic [13:0] in_oy;
  logic [3:0]  in_om;
  logic [4:0]  in_od;

  // Working registers.
  logic        start_ok;
  logic        other_ok;
  logic [21:0] start_days;
  logic [22:0] diff;
  logic [23:0] z;
  logic        in_range;
  logic [13:0] y_acc;
  logic [3:0]  bit_idx;
  logic [21:0] cand_days;
  logic [21:0] ys;
  logic        leap_y;
  logic [8:0]  doy;
  logic [3:0]  month;

  // Combinational helpers.
  logic [13:0] cand;
  logic [13:0] days_arg;
  logic [21:0] days_val;
  logic [13:0] start_yy;
  logic [13:0] other_yy;
  logic [21:0] other_days;
  logic [23:0] z_calc;
  logic [4:0]  cur_len;

  assign start_yy = (in_sm <= 4'd2) ? in_sy - 14'd1 : in_sy;
  assign other_yy = (in_om <= 4'd2) ? in_oy - 14'd1 : in_oy;
  assign cand     = y_acc | (14'd1 << bit_idx);

  // Shared day-count unit, argument chosen by the current command.
  always_comb begin
    case (cmd.op)
      OP_YEAR_EVAL:  days_arg = cand - 14'd1;
      OP_OTHER_DAYS: days_arg = other_yy;
      default:       days_arg = start_yy;
    endcase
  end
  assign days_val = year_days(days_arg);

  assign other_days = days_val + 22'(month_offset(in_om)) + 22'(in_od) - 22'd1;

  // Target day count for modes that move a date.
  assign z_calc = (in_mode == MODE_ADD) ? {2'b00, start_days} + {2'b00, in_off}
                                        : {2'b00, start_days} - {2'b00, in_off};

  assign cur_len = month_len(leap_y, month);

  // Status toward the controller.
  assign stat.start_ok    = start_ok;
  assign stat.other_ok    = other_ok;
  assign stat.mode_ok     = (in_mode != MODE_RSVD);
  assign stat.is_diff     = (in_mode == MODE_DIFF);
  assign stat.in_range    = in_range;
  assign stat.search_last = (bit_idx == 4'd0);
  assign stat.month_found = ({4'b0000, cur_len} > doy);

  // Datapath registers, updated by command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_mode <= mode;
        in_sy   <= start_year;
        in_sm   <= start_month;
        in_sd   <= start_day;
        in_off  <= offset_days;
        in_oy   <= other_year;
        in_om   <= other_month;
        in_od   <= other_day;
      end
      OP_CHECK: begin
        start_ok <= date_ok(in_sy, in_sm, in_sd);
        other_ok <= date_ok(in_oy, in_om, in_od);
      end
      OP_START_DAYS: begin
        start_days <= days_val + 22'(month_offset(in_sm)) + 22'(in_sd) - 22'd1;
      end
      OP_OTHER_DAYS: begin
        diff <= {1'b0, start_days} - {1'b0, other_days};
      end
      OP_RANGE: begin
        z        <= z_calc;
        in_range <= !z_calc[23] && (z_calc[22:0] >= {1'b0, DAY_FIRST})
                    && (z_calc[22:0] <= {1'b0, DAY_LAST});
        y_acc    <= 14'd0;
        bit_idx  <= YEAR_MSB;
      end
      OP_YEAR_EVAL: begin
        cand_days <= days_val + 22'(JAN1_OFFSET);
      end
      OP_YEAR_DECIDE: begin
        // Keep this year bit when the candidate is within YEAR_MAX and its January 1 is not past the target.
        if ((cand <= YEAR_MAX) && (cand_days <= z[21:0])) begin
          y_acc <= cand;
          ys    <= cand_days;
        end
        bit_idx <= bit_idx - 4'd1;
      end
      OP_LEAP: begin
        leap_y <= is_leap(y_acc);
        doy    <= 9'(z[21:0] - ys);
        month  <= 4'd1;
      end
      OP_MONTH_STEP: begin
        doy   <= doy - {4'b0000, cur_len};
        month <= month + 4'd1;
      end
      OP_EMIT_ERROR: begin
        result_year    <= 14'd0;
        result_month   <= 4'd0;
        result_day     <= 5'd0;
        day_difference <= 23'd0;
        status         <= cmd.err_code;
      end
      OP_EMIT_DIFF: begin
        result_year    <= 14'd0;
        result_month   <= 4'd0;
        result_day     <= 5'd0;
        day_difference <= diff;
        status         <= ST_OK;
      end
      OP_EMIT_DATE: begin
        result_year    <= y_acc;
        result_month   <= month;
        result_day     <= 5'(doy) + 5'd1;
        day_difference <= 23'd0;
        status         <= ST_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/calendar_date_day_arithmetic_top.sv @@
// Top level of the Gregorian date add, subtract and difference block.
`timescale 1ns / 1ps

// A beat is taken on a clock edge with start high and busy low; busy then stays
// high until the result appears. Each result is shown for one cycle with done
// high and must be taken in that cycle: there is no way to hold it off. An
// invalid input is answered after the validity check, a difference (mode 2)
// after the second day count, and an out-of-range result after the range
// check. Adding or subtracting days with an in-range result runs a 14-step
// binary search for the year, each step an evaluation on the shared day-count
// unit and a decision, then walks up to 12 months, one per cycle. Results stay
// on the ports until the next done but are only meaningful while done is high.
module calendar_date_day_arithmetic_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  mode,
  input  logic [13:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [21:0] offset_days,
  input  logic [13:0] other_year,
  input  logic [3:0]  other_month,
  input  logic [4:0]  other_day,
  output logic [13:0] result_year,
  output logic [3:0]  result_month,
  output logic [4:0]  result_day,
  output logic [22:0] day_difference,
  output logic [1:0]  status
);
  import cdda_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  cdda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Arithmetic and result registers.
  cdda_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .start_year     (start_year),
    .start_month    (start_month),
    .start_day      (start_day),
    .offset_days    (offset_days),
    .other_year     (other_year),
    .other_month    (other_month),
    .other_day      (other_day),
    .result_year    (result_year),
    .result_month   (result_month),
    .result_day     (result_day),
    .day_difference (day_difference),
    .status         (status)
  );

endmodule

@@ rtl/cdda_checker.sv @@
// Port-level checker for the date arithmetic block and its bind to the top level.
`timescale 1ns / 1ps

module cdda_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [13:0] result_year,
  input logic [3:0]  result_month,
  input logic [4:0]  result_day,
  input logic [22:0] day_difference,
  input logic [1:0]  status
);
  import cdda_pkg::*;

  // An accepted beat makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // A result only follows a beat in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a beat in progress");

  // The block is free again in the cycle its result is shown.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high while result is shown");

  // A failed beat carries no date and no difference.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((result_year == 14'd0) && (result_month == 4'd0)
                                     && (result_day == 5'd0) && (day_difference == 23'd0)))
    else $error("failed beat carries data");

  // A good date result is a full date and carries no difference.
  a_date_whole: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK) && (result_month != 4'd0))
      |-> ((result_day != 5'd0) && (result_year != 14'd0) && (day_difference == 23'd0)))
    else $error("date result is incomplete");

endmodule

bind calendar_date_day_arithmetic_top cdda_checker u_cdda_checker (.*);

@@ test/calendar_date_day_arithmetic_checker.sv @@
// Checker for the date arithmetic block: predicts every result and compares it on done.
`timescale 1ns / 1ps

module calendar_date_day_arithmetic_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic [1:0]  mode,
  input  logic [13:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [21:0] offset_days,
  input  logic [13:0] other_year,
  input  logic [3:0]  other_month,
  input  logic [4:0]  other_day,
  input  logic [13:0] result_year,
  input  logic [3:0]  result_month,
  input  logic [4:0]  result_day,
  input  logic [22:0] day_difference,
  input  logic [1:0]  status,
  output int          failures,
  output int          pending_results
);
  import cdda_pkg::*;

  typedef struct {
    logic [13:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [22:0]  diff;
    status_code_t code;
  } date_result_t;

  date_result_t expected_dates[$];
  int           mismatches = 0;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, longint m);
    longint len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit legal_date(longint y, longint m, longint d);
    return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= 1) && (m <= MONTHS_PER_YEAR) &&
           (d >= 1) && (d <= month_days(y, m));
  endfunction

  // Days in all whole years before January 1 of year y.
  function automatic longint days_before_year(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  // Day count with January 1 of year 1 as day zero.
  function automatic longint day_number(longint y, longint m, longint d);
    longint n;
    n = days_before_year(y) + d - 1;
    for (longint k = 1; k < m; k++) n += month_days(y, k);
    return n;
  endfunction

  function automatic date_result_t predict_date_result(
    logic [1:0] op, logic [13:0] sy, logic [3:0] sm, logic [4:0] sd, logic [21:0] off,
    logic [13:0] oy, logic [3:0] om, logic [4:0] od);
    date_result_t r;
    longint       base;
    longint       z;
    longint       y;
    longint       m;
    longint       rem;
    r.year  = '0;
    r.month = '0;
    r.day   = '0;
    r.diff  = '0;
    r.code  = ST_OK;
    if (op == MODE_RSVD || !legal_date(sy, sm, sd)) begin
      r.code = ST_INVALID;
      return r;
    end
    base = day_number(sy, sm, sd);
    // Only difference mode needs the second date to be legal as well.
    if (op == MODE_DIFF) begin
      if (!legal_date(oy, om, od)) begin
        r.code = ST_INVALID;
      end else begin
        r.diff = 23'(base - day_number(oy, om, od));
      end
      return r;
    end
    z = (op == MODE_ADD) ? base + longint'(off) : base - longint'(off);
    if (z < 0 || z > day_number(YEAR_MAX, 12, 31)) begin
      r.code = ST_RANGE;
      return r;
    end
    // No year is longer than 366 days, so this start never overshoots.
    y = z / 366 + 1;
    while (days_before_year(y + 1) <= z) y++;
    rem = z - days_before_year(y);
    m   = 1;
    while (rem >= month_days(y, m)) begin
      rem -= month_days(y, m);
      m++;
    end
    r.year  = 14'(y);
    r.month = 4'(m);
    r.day   = 5'(rem + 1);
    return r;
  endfunction

  task automatic check_field(string field, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Results are compared before new commands are queued on the same edge.
  always @(posedge clk) begin
    date_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d diff %0d st %0d",
                   $time, result_year, result_month, result_day,
                   $signed(day_difference), status);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("result_year", want.year, result_year);
          check_field("result_month", want.month, result_month);
          check_field("result_day", want.day, result_day);
          check_field("day_difference", longint'($signed(want.diff)),
                      longint'($signed(day_difference)));
          check_field("status", want.code, status);
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(predict_date_result(mode, start_year, start_month, start_day,
                                                     offset_days, other_year, other_month,
                                                     other_day));
      end
    end
    failures        <= mismatches;
    pending_results <= expected_dates.size();
  end

endmodule

@@ test/tb_calendar_date_day_arithmetic_top.sv @@
// Testbench top: drives date commands into the block and reports the verdict.
`timescale 1ns / 1ps

module tb_calendar_date_day_arithmetic_top;
  import cdda_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 38;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic [1:0]  mode = '0;
  logic [13:0] start_year = '0;
  logic [3:0]  start_month = '0;
  logic [4:0]  start_day = '0;
  logic [21:0] offset_days = '0;
  logic [13:0] other_year = '0;
  logic [3:0]  other_month = '0;
  logic [4:0]  other_day = '0;
  logic [13:0] result_year;
  logic [3:0]  result_month;
  logic [4:0]  result_day;
  logic [22:0] day_difference;
  logic [1:0]  status;
  int          failures;
  int          pending_results;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          phase_idle[3] = '{0, 86, 37};

  calendar_date_day_arithmetic_top i_dut (.*);

  calendar_date_day_arithmetic_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("calendar_date_day_arithmetic_top verification failed");
      $finish;
    end
  end

  // Presents one command beat, waits for it to be taken, then idles at random.
  task automatic send_command(input logic [1:0] op, input logic [13:0] sy,
                              input logic [3:0] sm, input logic [4:0] sd,
                              input logic [21:0] off, input logic [13:0] oy,
                              input logic [3:0] om, input logic [4:0] od);
    mode        <= op;
    start_year  <= sy;
    start_month <= sm;
    start_day   <= sd;
    offset_days <= off;
    other_year  <= oy;
    other_month <= om;
    other_day   <= od;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly legal dates; days past 28 are sometimes beyond the end of the month.
  task automatic pick_date(output logic [13:0] y, output logic [3:0] m, output logic [4:0] d);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) y = 14'($urandom_range(4, 1));
    else if (roll < 16) y = 14'($urandom_range(9999, 9996));
    else if (roll < 26) y = 14'(100 * $urandom_range(99, 1));
    else y = 14'($urandom_range(9999, 1));
    m = 4'($urandom_range(12, 1));
    d = ($urandom_range(99) < 80) ? 5'($urandom_range(28, 1)) : 5'($urandom_range(31, 29));
  endtask

  task automatic send_random_command();
    logic [1:0]  op;
    logic [13:0] sy;
    logic [13:0] oy;
    logic [3:0]  sm;
    logic [3:0]  om;
    logic [4:0]  sd;
    logic [4:0]  od;
    logic [21:0] off;
    int          kind;
    kind = $urandom_range(99);
    pick_date(sy, sm, sd);
    pick_date(oy, om, od);
    off = 22'($urandom);
    if (kind < 15) begin
      // Noise: every field carries arbitrary bits.
      op = 2'($urandom);
      sy = 14'($urandom);
      sm = 4'($urandom);
      sd = 5'($urandom);
      oy = 14'($urandom);
      om = 4'($urandom);
      od = 5'($urandom);
    end else if (kind < 35) begin
      op = MODE_DIFF;
    end else begin
      op = $urandom_range(1) ? MODE_SUB : MODE_ADD;
      case ($urandom_range(2))
        0:       off = 22'($urandom_range(400));
        1:       off = 22'($urandom_range(40000));
        default: off = 22'($urandom);
      endcase
    end
    send_command(op, sy, sm, sd, off, oy, om, od);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Leap days, month and year rollover.
    send_command(MODE_ADD, 14'd2024, 4'd2, 5'd28, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd2023, 4'd2, 5'd28, 22'd1, '0, '0, '0);
    send_command(MODE_SUB, 14'd2000, 4'd3, 5'd1, 22'd1, '0, '0, '0);
    send_command(MODE_SUB, 14'd1900, 4'd3, 5'd1, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd1999, 4'd12, 5'd31, 22'd1, '0, '0, '0);
    // Edges of the calendar range, inside and just beyond.
    send_command(MODE_ADD, 14'd9999, 4'd12, 5'd31, 22'd0, '0, '0, '0);
    send_command(MODE_ADD, 14'd9999, 4'd12, 5'd31, 22'd1, '0, '0, '0);
    send_command(MODE_SUB, 14'd1, 4'd1, 5'd1, 22'd0, '0, '0, '0);
    send_command(MODE_SUB, 14'd1, 4'd1, 5'd1, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd1, 4'd1, 5'd1, 22'd3652058, '0, '0, '0);
    send_command(MODE_SUB, 14'd9999, 4'd12, 5'd31, 22'd3652058, '0, '0, '0);
    send_command(MODE_ADD, 14'd1, 4'd1, 5'd1, 22'h3FFFFF, '0, '0, '0);
    send_command(MODE_SUB, 14'd9999, 4'd12, 5'd31, 22'h3FFFFF, '0, '0, '0);
    // Differences at both extremes, zero, and with an illegal second date.
    send_command(MODE_DIFF, 14'd9999, 4'd12, 5'd31, '0, 14'd1, 4'd1, 5'd1);
    send_command(MODE_DIFF, 14'd1, 4'd1, 5'd1, '0, 14'd9999, 4'd12, 5'd31);
    send_command(MODE_DIFF, 14'd2024, 4'd7, 5'd15, '0, 14'd2024, 4'd7, 5'd15);
    send_command(MODE_DIFF, 14'd2024, 4'd7, 5'd15, '0, 14'd2024, 4'd13, 5'd1);
    send_command(MODE_DIFF, 14'd2024, 4'd7, 5'd15, '0, 14'd1900, 4'd2, 5'd29);
    send_command(MODE_DIFF, 14'd500, 4'd5, 5'd5, 22'h3FFFFF, 14'h3FFF, 4'hF, 5'h1F);
    // Illegal start dates and the unused mode.
    send_command(MODE_ADD, 14'd1900, 4'd2, 5'd29, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd2020, 4'd4, 5'd31, 22'd1, '0, '0, '0);
    send_command(MODE_SUB, 14'd2020, 4'd6, 5'd0, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd2020, 4'd0, 5'd10, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'h3FFF, 4'hF, 5'h1F, 22'd1, '0, '0, '0);
    send_command(MODE_SUB, 14'd0, 4'd6, 5'd10, 22'd1, '0, '0, '0);
    send_command(MODE_ADD, 14'd10000, 4'd1, 5'd1, 22'd0, '0, '0, '0);
    send_command(MODE_RSVD, 14'd2020, 4'd6, 5'd10, 22'd5, 14'd2020, 4'd6, 5'd10);

    // Random phases with different amounts of sender idling.
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_command();
      if (p == 0) begin
        // Hold off until every outstanding result has come back.
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0 || busy) @(posedge clk);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("calendar_date_day_arithmetic_top verification clean");
    end else begin
      $display("calendar_date_day_arithmetic_top verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cdda_pkg.sv
rtl/cdda_ctrl.sv
rtl/cdda_dp.sv
rtl/calendar_date_day_arithmetic_top.sv
rtl/cdda_checker.sv
test/calendar_date_day_arithmetic_checker.sv
test/tb_calendar_date_day_arithmetic_top.sv
